// File: src/nafmt_pkg.sv
// nafmt_pkg: shared types, format codes and ASCII helpers for the number formatter.
// Used by every module of number_to_ascii_formatter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nafmt_pkg;

  // format request codes
  typedef enum logic [2:0] {
    FMT_NIBBLE   = 3'd0,
    FMT_BYTE2    = 3'd1,
    FMT_BYTE_NL  = 3'd2,
    FMT_WORD_NL  = 3'd3,
    FMT_DEC      = 3'd4
  } fmt_t;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [3:0] NIB_TEN  = 4'd10;

  localparam int DIGITS   = 5;           // digit slots in the shift register
  localparam int DIG_W    = 4 * DIGITS;
  localparam int VAL_W    = 16;
  localparam int ITER_W   = $clog2(VAL_W);
  localparam int CNT_W    = $clog2(DIGITS + 1);

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] value;
  } in_word_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic       is_last;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CONV = 2'd1,
    S_NORM = 2'd2,
    S_EMIT = 2'd3
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input word
    logic step;   // one shift-add-3 iteration
    logic norm;   // strip leading decimal zeros, queue the space
    logic emit;   // push one character into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can take a character this cycle
    logic last_char;  // next emitted character ends the text
  } dp_stat_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < NIB_TEN) begin
      c = CH_ZERO + {3'b000, nib};
    end else begin
      c = CH_A + {3'b000, nib - NIB_TEN};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/number_to_ascii_formatter.sv
// number_to_ascii_formatter: top level, sequencer plus digit datapath.
// Depends on nafmt_pkg, nafmt_ctrl, nafmt_dp.
//
// Usage:
//   in_valid/in_stall/in_word carry one request word {req_type, value}.
//   out_valid/out_stall/out_word carry one ASCII character per word, most
//   significant first, is_last set on the final character of the text.
//   Formats 0..3 print hex digits; format 4 prints a space and the
//   decimal value. Codes 5..7 are accepted and produce nothing.
// Sequence:
//   Hex formats: 1 to 4 characters at one per cycle while out_stall is low,
//   next request taken the cycle after the last character is loaded.
//   Decimal: shift-add-3 conversion (one value bit per cycle), a step to
//   strip leading zeros, then 2 to 6 characters.
//   in_stall is high while a request is in progress.
// Reset (synchronous, rst_n low) empties the output register and returns
// to idle. A stalled output holds its character; the sequencer waits.
`timescale 1ns / 1ps
`default_nettype none

module number_to_ascii_formatter (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  nafmt_pkg::in_word_t    in_word,
  output logic                   out_valid,
  input  wire                    out_stall,
  output nafmt_pkg::out_word_t   out_word
);
  import nafmt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nafmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_word.req_type),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  nafmt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// File: src/nafmt_ctrl.sv
// nafmt_ctrl: sequencer for the number formatter.
// Depends on nafmt_pkg; drives nafmt_dp through dp_cmd_t, reads dp_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module nafmt_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  input  wire [2:0]              req_type,
  output logic                   in_stall,
  output nafmt_pkg::dp_cmd_t     cmd,
  input  nafmt_pkg::dp_stat_t    stat
);
  import nafmt_pkg::*;

  state_t              state_r, state_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic                known_fmt;

  assign known_fmt = (req_type == FMT_NIBBLE) || (req_type == FMT_BYTE2) ||
                     (req_type == FMT_BYTE_NL) || (req_type == FMT_WORD_NL) ||
                     (req_type == FMT_DEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    case (state_r)
      S_IDLE: begin
        iter_nxt = '0;
        // unknown formats are taken and dropped
        if (in_valid && known_fmt) begin
          state_nxt = (req_type == FMT_DEC) ? S_CONV : S_EMIT;
        end
      end
      S_CONV: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(VAL_W - 1)) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free && stat.last_char) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid && known_fmt;
      end
      S_CONV: cmd.step = 1'b1;
      S_NORM: cmd.norm = 1'b1;
      S_EMIT: cmd.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: src/nafmt_dp.sv
// nafmt_dp: digit shift register, binary-to-BCD converter and output register.
// Depends on nafmt_pkg; commanded by nafmt_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module nafmt_dp (
  input  wire                    clk,
  input  wire                    rst_n,
  input  nafmt_pkg::in_word_t    in_word,
  input  nafmt_pkg::dp_cmd_t     cmd,
  output nafmt_pkg::dp_stat_t    stat,
  output logic                   out_valid,
  input  wire                    out_stall,
  output nafmt_pkg::out_word_t   out_word
);
  import nafmt_pkg::*;

  // digits are MSB aligned: the next one to send sits in dig_r[DIG_W-1 -: 4]
  logic [DIG_W-1:0]  dig_r, dig_nxt;
  logic [VAL_W-1:0]  bin_r, bin_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              space_r, space_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic [DIG_W-1:0]  hex_dig;
  logic [CNT_W-1:0]  hex_cnt;
  logic [DIG_W-1:0]  bcd_adj;
  logic [DIG_W-1:0]  norm_dig;
  logic [CNT_W-1:0]  norm_cnt;
  logic [15:0]       v;

  assign v = in_word.value;

  // hex load: align digits; the _NL formats also drop leading zero nibbles
  always_comb begin
    hex_dig = '0;
    hex_cnt = CNT_W'(1);
    case (in_word.req_type)
      FMT_NIBBLE: begin
        hex_dig = {v[3:0], 16'h0000};
        hex_cnt = CNT_W'(1);
      end
      FMT_BYTE2: begin
        hex_dig = {v[7:0], 12'h000};
        hex_cnt = CNT_W'(2);
      end
      FMT_BYTE_NL: begin
        if (v[7:4] != 4'h0) begin
          hex_dig = {v[7:0], 12'h000};
          hex_cnt = CNT_W'(2);
        end else begin
          hex_dig = {v[3:0], 16'h0000};
          hex_cnt = CNT_W'(1);
        end
      end
      FMT_WORD_NL: begin
        if (v[15:12] != 4'h0) begin
          hex_dig = {v, 4'h0};
          hex_cnt = CNT_W'(4);
        end else if (v[11:8] != 4'h0) begin
          hex_dig = {v[11:0], 8'h00};
          hex_cnt = CNT_W'(3);
        end else if (v[7:4] != 4'h0) begin
          hex_dig = {v[7:0], 12'h000};
          hex_cnt = CNT_W'(2);
        end else begin
          hex_dig = {v[3:0], 16'h0000};
          hex_cnt = CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3
                                                    : dig_r[4*i +: 4];
    end
  end

  // leading zero strip of the BCD result, at least one digit
  always_comb begin
    if (dig_r[19:16] != 4'h0) begin
      norm_dig = dig_r;
      norm_cnt = CNT_W'(5);
    end else if (dig_r[15:12] != 4'h0) begin
      norm_dig = {dig_r[15:0], 4'h0};
      norm_cnt = CNT_W'(4);
    end else if (dig_r[11:8] != 4'h0) begin
      norm_dig = {dig_r[11:0], 8'h00};
      norm_cnt = CNT_W'(3);
    end else if (dig_r[7:4] != 4'h0) begin
      norm_dig = {dig_r[7:0], 12'h000};
      norm_cnt = CNT_W'(2);
    end else begin
      norm_dig = {dig_r[3:0], 16'h0000};
      norm_cnt = CNT_W'(1);
    end
  end

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.last_char = !space_r && (cnt_r == CNT_W'(1));

  always_comb begin
    dig_nxt       = dig_r;
    bin_nxt       = bin_r;
    cnt_nxt       = cnt_r;
    space_nxt     = space_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load) begin
      space_nxt = 1'b0;
      bin_nxt   = v;
      if (in_word.req_type == FMT_DEC) begin
        dig_nxt = '0;
      end else begin
        dig_nxt = hex_dig;
        cnt_nxt = hex_cnt;
      end
    end
    if (cmd.step) begin
      {dig_nxt, bin_nxt} = {bcd_adj[DIG_W-2:0], bin_r, 1'b0};
    end
    if (cmd.norm) begin
      dig_nxt   = norm_dig;
      cnt_nxt   = norm_cnt;
      space_nxt = 1'b1;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (space_r) begin
        space_nxt               = 1'b0;
        out_word_nxt.ascii_char = CH_SPACE;
        out_word_nxt.is_last    = 1'b0;
      end else begin
        out_word_nxt.ascii_char = hex_char(dig_r[DIG_W-1 -: 4]);
        out_word_nxt.is_last    = (cnt_r == CNT_W'(1));
        dig_nxt                 = {dig_r[DIG_W-5:0], 4'h0};
        cnt_nxt                 = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      space_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      space_r     <= space_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    bin_r      <= bin_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// File: src/nafmt_chk.sv
// nafmt_chk: port-level checks for number_to_ascii_formatter, bound to the top.
// Depends on nafmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nafmt_chk (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_stall,
  input nafmt_pkg::in_word_t   in_word,
  input wire                   out_valid,
  input wire                   out_stall,
  input nafmt_pkg::out_word_t  out_word
);
  import nafmt_pkg::*;

  logic unk_fmt;

  // codes above the decimal format are reserved
  assign unk_fmt = (in_word.req_type > FMT_DEC);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // unknown format is dropped and the block stays ready
  a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && unk_fmt |=> !in_stall)
    else $error("unknown format not dropped");

  // a valid request keeps the input busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !unk_fmt |=> in_stall)
    else $error("request accepted without going busy");

  // the leading space of decimal text never ends it
  a_space_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.ascii_char == CH_SPACE) |-> !out_word.is_last)
    else $error("space marked as last character");

endmodule

bind number_to_ascii_formatter nafmt_chk u_nafmt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
